// ===== rtl/core/simplex_noise_3d_top_macros.svh =====
// Assertion macros used by the simplex noise top level.
`ifndef SIMPLEX_NOISE_3D_TOP_MACROS_SVH
`define SIMPLEX_NOISE_3D_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SNZ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("simplex noise: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SNZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("simplex noise: next-cycle check failed");

`endif

// ===== rtl/core/snz_pkg.sv =====
// Package with the types, constants and lookup functions of the simplex noise block.
`default_nettype none

package snz_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PERM_SIZE  = 256;
    localparam int OFS_W      = 24;
    localparam int CONTRIB_W  = 57;
    localparam int CELL_LAT   = 6;
    localparam int CORNER_LAT = 8;
    localparam int PIPE_LAT   = CELL_LAT + CORNER_LAT + 2;

    typedef logic signed [OFS_W-1:0] t_ofs;
    typedef logic signed [OFS_W+1:0] t_dot;
    typedef logic [3:0]              t_grad;
    typedef logic signed [CONTRIB_W-1:0] t_contrib;

    typedef struct packed {
        t_ofs dx;
        t_ofs dy;
        t_ofs dz;
    } t_vec;

    // One cell edge and one unit in offset units of 1/(6 * 2^FRAC_BITS).
    localparam logic [OFS_W-1:0] CELL_STEP = OFS_W'(6 << FRAC_BITS);

    localparam logic [7:0] PERM_ROM [PERM_SIZE] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx, input logic [7:0] key);
        return PERM_ROM[idx] ^ key;
    endfunction

    // Remainder by 12 through a reciprocal multiply, exact for all 8-bit values.
    function automatic t_grad grad_sel(input logic [7:0] v);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(v) * 16'd171;
        q = {3'b000, p[15:11]};
        r = v - 8'(q * 8'd12);
        return r[3:0];
    endfunction

    // Dot product with one of the twelve cube-edge gradients.
    function automatic t_dot grad_dot(input t_grad g, input t_ofs dx, input t_ofs dy,
                                      input t_ofs dz);
        t_dot ex;
        t_dot ey;
        t_dot ez;
        t_dot d;
        ex = {{2{dx[OFS_W-1]}}, dx};
        ey = {{2{dy[OFS_W-1]}}, dy};
        ez = {{2{dz[OFS_W-1]}}, dz};
        case (g)
            4'd0:    d =  ex + ey;
            4'd1:    d = -ex + ey;
            4'd2:    d =  ex - ey;
            4'd3:    d = -ex - ey;
            4'd4:    d =  ex + ez;
            4'd5:    d = -ex + ez;
            4'd6:    d =  ex - ez;
            4'd7:    d = -ex - ez;
            4'd8:    d =  ey + ez;
            4'd9:    d = -ey + ez;
            4'd10:   d =  ey - ez;
            4'd11:   d = -ey - ez;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/snz_cell.sv =====
// Skew, cell floor division, corner ranking and permutation hashing stages.
`default_nettype none

module snz_cell (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [31:0]  i_x,
    input  wire logic signed [31:0]  i_y,
    input  wire logic signed [31:0]  i_z,
    input  wire logic [7:0]          i_key,
    output snz_pkg::t_vec            o_vec  [4],
    output snz_pkg::t_grad           o_grad [4]
);
    import snz_pkg::*;

    logic signed [31:0] w_in [3];
    logic signed [34:0] w_n  [3];
    logic [20:0]        r1_u [3];
    logic [OFS_W-1:0]   r1_p [3];
    logic [7:0]         r2_i [3];
    logic [OFS_W-1:0]   r2_p [3];
    logic [43:0]        w_q  [3];
    logic [7:0]         w_ijk;
    t_ofs               w_o  [3];
    t_ofs               r3_o [3];
    logic [7:0]         r3_c [3];
    logic               w_xy, w_yz, w_xz;
    logic [2:0]         w_off [4];
    t_ofs               w_d  [4][3];
    logic [7:0]         w_pk [4];
    t_vec               r4_vec [4];
    logic [2:0]         r4_off [4];
    logic [7:0]         r4_pk  [4];
    logic [7:0]         r4_c   [2];
    logic [7:0]         w_pj   [4];
    t_vec               r5_vec [4];
    logic [2:0]         r5_off [4];
    logic [7:0]         r5_pj  [4];
    logic [7:0]         r5_c;
    t_grad              w_g    [4];
    t_vec               r6_vec [4];
    t_grad              r6_grad [4];

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;

    // Skewed axis sum 4a + b + c; its floor by 3 * 2^16 is the cell index.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_n[a] = {{2{w_in[a][31]}}, w_in[a], 1'b0} + {{3{w_in[a][31]}}, w_in[a]}
                   + {{3{i_x[31]}}, i_x} + {{3{i_y[31]}}, i_y} + {{3{i_z[31]}}, i_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                // Biased to non-negative so a reciprocal multiply gives the floor.
                r1_u[a] <= {{2{w_n[a][34]}}, w_n[a][34:FRAC_BITS]} + 21'd786432;
                r1_p[a] <= w_in[a][OFS_W-1:0];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_q[a] = 44'(r1_u[a]) * 44'd1398102;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r2_i[a] <= w_q[a][29:22];
                r2_p[a] <= r1_p[a];
            end
        end
    end

    // Offsets from the cell origin only need modulo-2^24 arithmetic.
    always_comb begin
        w_ijk = r2_i[0] + r2_i[1] + r2_i[2];
        for (int a = 0; a < 3; a++) begin
            w_o[a] = t_ofs'(r2_p[a] * 24'd6 - {8'(r2_i[a] * 8'd6), 16'h0000}
                     + {w_ijk, 16'h0000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_o <= w_o;
            r3_c <= r2_i;
        end
    end

    // Rank the offsets; bit 0 is the x step, bit 1 y, bit 2 z.
    always_comb begin
        w_xy = r3_o[0] >= r3_o[1];
        w_yz = r3_o[1] >= r3_o[2];
        w_xz = r3_o[0] >= r3_o[2];
        w_off[0] = 3'b000;
        w_off[3] = 3'b111;
        if (w_xy) begin
            if (w_yz) begin
                w_off[1] = 3'b001; w_off[2] = 3'b011;
            end else if (w_xz) begin
                w_off[1] = 3'b001; w_off[2] = 3'b101;
            end else begin
                w_off[1] = 3'b100; w_off[2] = 3'b101;
            end
        end else begin
            if (!w_yz) begin
                w_off[1] = 3'b100; w_off[2] = 3'b110;
            end else if (!w_xz) begin
                w_off[1] = 3'b010; w_off[2] = 3'b110;
            end else begin
                w_off[1] = 3'b010; w_off[2] = 3'b011;
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int a = 0; a < 3; a++) begin
                w_d[c][a] = t_ofs'(r3_o[a] - (w_off[c][a] ? CELL_STEP : '0)
                            + (OFS_W'(c) << FRAC_BITS));
            end
            w_pk[c] = perm_lookup(r3_c[2] + 8'(w_off[c][2]), i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r4_vec[c] <= '{dx: w_d[c][0], dy: w_d[c][1], dz: w_d[c][2]};
            end
            r4_off <= w_off;
            r4_pk  <= w_pk;
            r4_c[0] <= r3_c[0];
            r4_c[1] <= r3_c[1];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_pj[c] = perm_lookup(r4_c[1] + 8'(r4_off[c][1]) + r4_pk[c], i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_vec <= r4_vec;
            r5_off <= r4_off;
            r5_pj  <= w_pj;
            r5_c   <= r4_c[0];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_g[c] = grad_sel(perm_lookup(r5_c + 8'(r5_off[c][0]) + r5_pj[c], i_key));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_vec  <= r5_vec;
            r6_grad <= w_g;
        end
    end

    assign o_vec  = r6_vec;
    assign o_grad = r6_grad;

endmodule

`default_nettype wire

// ===== rtl/core/snz_corner.sv =====
// Falloff and gradient contribution pipeline for one tetrahedron corner.
`default_nettype none

module snz_corner (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire snz_pkg::t_vec   i_vec,
    input  wire snz_pkg::t_grad  i_grad,
    output snz_pkg::t_contrib    o_contrib
);
    import snz_pkg::*;

    localparam logic [47:0] RECIP_45 = 48'd1527099484;

    logic signed [47:0] r1_sx, r1_sy, r1_sz;
    t_dot               r_dot [CORNER_LAT-1];
    logic signed [52:0] w_sq;
    logic signed [52:0] w_t5;
    logic [34:0]        w_v;
    logic [16:0]        r2_a, r3_a;
    logic [17:0]        r2_b, r3_b;
    logic [47:0]        w_p1;
    logic [11:0]        r3_q1, r4_q1;
    logic [16:0]        w_r1;
    logic [23:0]        r4_u;
    logic [54:0]        w_p2;
    logic [29:0]        r5_tq, r6_t2, r7_t4;
    logic [59:0]        w_s2, w_s4;
    t_contrib           r8_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx    <= i_vec.dx * i_vec.dx;
            r1_sy    <= i_vec.dy * i_vec.dy;
            r1_sz    <= i_vec.dz * i_vec.dz;
            r_dot[0] <= grad_dot(i_grad, i_vec.dx, i_vec.dy, i_vec.dz);
            for (int s = 1; s < CORNER_LAT - 1; s++) begin
                r_dot[s] <= r_dot[s-1];
            end
        end
    end

    // Falloff 0.6 - |d|^2 in units of 1/(180 * 2^32); out of reach gives zero.
    always_comb begin
        w_sq = 53'(r1_sx) + 53'(r1_sy) + 53'(r1_sz);
        w_t5 = (53'sd108 <<< 32) - ((w_sq <<< 2) + w_sq);
        w_v  = (w_t5 > 53'sd0) ? w_t5[38:4] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a <= w_v[34:18];
            r2_b <= w_v[17:0];
        end
    end

    // Divide by 45 in two digits: high part first, then remainder and low part.
    assign w_p1 = 48'(r2_a) * RECIP_45;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_q1 <= w_p1[47:36];
            r3_a  <= r2_a;
            r3_b  <= r2_b;
        end
    end

    assign w_r1 = r3_a - 17'(r3_q1 * 17'd45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_q1 <= r3_q1;
            r4_u  <= {w_r1[5:0], r3_b};
        end
    end

    assign w_p2 = 55'(r4_u) * 55'(RECIP_45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_tq <= {r4_q1, w_p2[53:36]};
        end
    end

    assign w_s2 = 60'(r5_tq) * 60'(r5_tq);
    assign w_s4 = 60'(r6_t2) * 60'(r6_t2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_t2 <= w_s2[59:30];
            r7_t4 <= w_s4[59:30];
            r8_c  <= $signed({1'b0, r7_t4}) * r_dot[CORNER_LAT-2];
        end
    end

    assign o_contrib = r8_c;

endmodule

`default_nettype wire

// ===== rtl/core/simplex_noise_3d_top.sv =====
// Top level of the pipelined 3D simplex noise evaluator.
`default_nettype none

`include "simplex_noise_3d_top_macros.svh"

// Evaluates 3D simplex noise for one point per transaction: the point comes in as
// signed Q15.16 x, y and z, and the result leaves as a signed Q1.15 value rounded
// to nearest and saturated. The datapath is a 16-stage pipeline that accepts a new
// transaction every clock cycle while the output side is not stalled. The whole
// pipeline advances together, so a stall on the output holds every stage and
// nothing is dropped or repeated. The first six stages find the simplex cell, rank
// the corners and run the three permutation lookups for each corner; four identical
// eight-stage corner units then form the falloff, its fourth power and the gradient
// product, and the last two stages sum, scale and saturate. The seed is to be
// written through i_seed_we / i_seed only while no transaction is in flight; the
// block itself does not enforce this. Its four bytes are folded by XOR into the key
// that is applied to every permutation entry.
module simplex_noise_3d_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seed_we,
    input  wire logic [31:0]        i_seed,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_x_coord,
    input  wire logic signed [31:0] i_y_coord,
    input  wire logic signed [31:0] i_z_coord,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_noise_value
);
    import snz_pkg::*;

    logic                r_key_dummy;
    logic [7:0]          r_key;
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    t_vec                w_vec  [4];
    t_grad               w_grad [4];
    t_contrib            w_c    [4];
    logic signed [58:0]  w_tot;
    logic [26:0]         w_u;
    logic [26:0]         r_u;
    logic [53:0]         w_prod;
    logic signed [25:0]  w_q;
    logic signed [15:0]  r_noise;

    // Every stage moves when the last one is empty or its result is taken.
    assign w_en    = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_key_dummy <= 1'b0;
        end else if (i_seed_we) begin
            r_key       <= i_seed[31:24] ^ i_seed[23:16] ^ i_seed[15:8] ^ i_seed[7:0];
            r_key_dummy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    snz_cell u_cell (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (i_x_coord),
        .i_y    (i_y_coord),
        .i_z    (i_z_coord),
        .i_key  (r_key),
        .o_vec  (w_vec),
        .o_grad (w_grad)
    );

    for (genvar c = 0; c < 4; c++) begin : g_corner
        snz_corner u_corner (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_vec     (w_vec[c]),
            .i_grad    (w_grad[c]),
            .o_contrib (w_c[c])
        );
    end

    // Sum plus half of 6 * 2^26 for rounding; dividing by 2^27 leaves a floor by 3.
    always_comb begin
        w_tot = {{2{w_c[0][CONTRIB_W-1]}}, w_c[0]} + {{2{w_c[1][CONTRIB_W-1]}}, w_c[1]}
              + {{2{w_c[2][CONTRIB_W-1]}}, w_c[2]} + {{2{w_c[3][CONTRIB_W-1]}}, w_c[3]}
              + 59'sd201326592;
        w_u   = w_tot[53:27] + 27'd50331648;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u <= w_u;
        end
    end

    // Reciprocal multiply for the floor by 3, then remove the bias and saturate.
    always_comb begin
        w_prod = 54'(r_u) * 54'd89478486;
        w_q    = $signed(w_prod[53:28] - 26'd16777216);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_q > 26'sd32767) begin
                r_noise <= 16'sh7fff;
            end else if (w_q < -26'sd32768) begin
                r_noise <= -16'sh8000;
            end else begin
                r_noise <= w_q[15:0];
            end
        end
    end

    assign o_noise_value = r_noise;

    // A held pipeline keeps every valid bit where it was.
    `SNZ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, r_vld == $past(r_vld))
    // An advancing pipeline shifts every valid bit one stage on.
    `SNZ_ASSERT_NEXT(a_shift, i_clk, i_rst_n, w_en, r_vld[PIPE_LAT-1:1] == $past(r_vld[PIPE_LAT-2:0]))
    // An accepted transaction occupies the first stage in the next cycle.
    `SNZ_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])
    // A waiting result blocks new transactions.
    `SNZ_ASSERT_IMPLY(a_block, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
    // The key follows the last seed write.
    `SNZ_ASSERT_NEXT(a_key, i_clk, i_rst_n, i_seed_we, r_key_dummy && r_key == $past(i_seed[31:24] ^ i_seed[23:16] ^ i_seed[15:8] ^ i_seed[7:0]))

endmodule

`default_nettype wire
